@@ sv/kld_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kld_pkg
// Shared register codes and fixed widths of the KLD sample count bound.
// ----------------------------------------------------------------------------
package kld_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_Z_QUANTILE  = 2'd0;
    localparam logic [1:0] REG_ERROR_BOUND = 2'd1;
    localparam logic [1:0] REG_MIN_SAMPLES = 2'd2;
    localparam logic [1:0] REG_MAX_SAMPLES = 2'd3;

    // Register reset values.
    localparam logic [15:0] Z_QUANTILE_RST  = 16'd12288;
    localparam logic [15:0] ERROR_BOUND_RST = 16'd3277;
    localparam logic [19:0] MIN_SAMPLES_RST = 20'd100;
    localparam logic [19:0] MAX_SAMPLES_RST = 20'd5000;

    // Quotient bits of the final division; a quotient of 2^QBITS or more gives the maximum count.
    localparam int QBITS = 21;

endpackage

@@ sv/kld_sample_count_bound.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kld_sample_count_bound
// Fully pipelined KLD-sampling particle count with clamping.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the output register is not stalled; a
// long-division stage per quotient bit of both divisions, a square-root stage
// per root bit and one stage per multiply set most of the depth.
// The pipeline holds as a whole while the output register waits for tready.
// Reset (rst_n low, asynchronous) clears all valid bits and loads the register
// defaults; data registers are not reset.
module kld_sample_count_bound
    import kld_pkg::*;
#(
    parameter int MAX_CELLS = 65536,
    parameter int FRAC_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream; s_tdata[16:0] = occupied_cells.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // Output stream; m_tdata[19:0] = sample_limit.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int F   = FRAC_BITS;
    localparam int KMW = $clog2(MAX_CELLS);
    localparam int DW  = KMW + 4;
    localparam int QB  = F + 2;
    localparam int A   = QB + F;
    localparam int B   = A + 6 + QBITS;
    localparam int L   = B + 1;
    localparam int PW  = KMW + F + 1;
    localparam int XW  = (PW + 16 > F + QBITS + 1) ? PW + 16 : F + QBITS + 1;

    typedef struct packed {
        logic             lt2;
        logic             neg;
        logic             sat;
        logic             sticky;
        logic [KMW-1:0]   km1;
        logic [F-1:0]     cq;
        logic [QBITS-1:0] xb;
    } ctl_t;

    // Configuration registers.
    logic [15:0] z_quantile_reg;
    logic [15:0] error_bound_reg;
    logic [19:0] min_samples_reg;
    logic [19:0] max_samples_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_quantile_reg  <= Z_QUANTILE_RST;
            error_bound_reg <= ERROR_BOUND_RST;
            min_samples_reg <= MIN_SAMPLES_RST;
            max_samples_reg <= MAX_SAMPLES_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_Z_QUANTILE:  z_quantile_reg  <= pwdata[15:0];
                REG_ERROR_BOUND: error_bound_reg <= pwdata[15:0];
                REG_MIN_SAMPLES: min_samples_reg <= pwdata[19:0];
                REG_MAX_SAMPLES: max_samples_reg <= pwdata[19:0];
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_Z_QUANTILE:  prdata = {16'd0, z_quantile_reg};
            REG_ERROR_BOUND: prdata = {16'd0, error_bound_reg};
            REG_MIN_SAMPLES: prdata = {12'd0, min_samples_reg};
            REG_MAX_SAMPLES: prdata = {12'd0, max_samples_reg};
        endcase
    end

    // Pipeline registers.
    logic                 adv;
    logic [L-1:0]         vld_reg;
    ctl_t                 ctl_reg  [L];
    ctl_t                 ctl_next [L];
    logic [DW-1:0]        drem_reg [1:QB];
    logic [DW-1:0]        drem_next[1:QB];
    logic [QB-1:0]        dq_reg   [1:QB];
    logic [QB-1:0]        dq_next  [1:QB];
    logic [F+1:0]         sr_reg   [1:F];
    logic [F+1:0]         sr_next  [1:F];
    logic [F-1:0]         sroot_reg[1:F];
    logic [F-1:0]         sroot_next[1:F];
    logic [F+15:0]        mp_reg;
    logic [F:0]           tt_reg;
    logic [F:0]           tt_d_reg;
    logic [F:0]           t2_reg;
    logic [F:0]           t3_reg;
    logic [PW-1:0]        pp_reg;
    logic [15:0]          r2_reg   [0:QBITS];
    logic [15:0]          r2_next  [0:QBITS];
    logic [QBITS-1:0]     q2_reg   [1:QBITS];
    logic [QBITS-1:0]     q2_next  [1:QBITS];
    logic                 out_valid_reg;
    logic [19:0]          out_data_reg;
    logic [19:0]          out_data_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};

    // Long division 2^(F+1) / (9(k-1)), one quotient bit per stage.
    always_comb
    begin
        logic [DW-1:0] prev_r;
        logic [QB-1:0] prev_q;
        logic [DW-1:0] dv;
        logic [DW:0]   cur;
        for (int j = 1; j <= QB; j++)
        begin
            if (j == 1)
            begin
                prev_r = '0;
                prev_q = '0;
            end
            else
            begin
                prev_r = drem_reg[j-1];
                prev_q = dq_reg[j-1];
            end
            dv  = (DW'(ctl_reg[j-1].km1) << 3) + DW'(ctl_reg[j-1].km1);
            cur = {prev_r, (j == 1)};
            if (cur >= {1'b0, dv})
            begin
                drem_next[j] = DW'(cur - {1'b0, dv});
                dq_next[j]   = {prev_q[QB-2:0], 1'b1};
            end
            else
            begin
                drem_next[j] = cur[DW-1:0];
                dq_next[j]   = {prev_q[QB-2:0], 1'b0};
            end
        end
    end

    // Square root of cq * 2^F, two radicand bits per stage.
    always_comb
    begin
        logic [F+1:0]   prev_r;
        logic [F-1:0]   prev_q;
        logic [2*F-1:0] rad;
        logic [F+3:0]   cur;
        logic [F+3:0]   trial;
        for (int s = 1; s <= F; s++)
        begin
            if (s == 1)
            begin
                prev_r = '0;
                prev_q = '0;
            end
            else
            begin
                prev_r = sr_reg[s-1];
                prev_q = sroot_reg[s-1];
            end
            rad   = {ctl_reg[QB+s-1].cq, {F{1'b0}}};
            cur   = {prev_r, rad[2*(F-s) +: 2]};
            trial = {2'b00, prev_q, 2'b01};
            if (cur >= trial)
            begin
                sr_next[s]    = (F+2)'(cur - trial);
                sroot_next[s] = {prev_q[F-2:0], 1'b1};
            end
            else
            begin
                sr_next[s]    = cur[F+1:0];
                sroot_next[s] = {prev_q[F-2:0], 1'b0};
            end
        end
    end

    // Subtraction stage: T = 1 - c - sqrt(c)*z.
    logic [F+4:0] sub_sum;
    logic [F+4:0] one_ext;
    logic         sub_neg;
    assign one_ext = (F+5)'(1) << F;
    assign sub_sum = (F+5)'(ctl_reg[A+1].cq) + (F+5)'(mp_reg[F+15:12]);
    assign sub_neg = sub_sum >= one_ext;

    // Saturation test and split of (k-1)*t^3*2^15 for the final division.
    logic [XW-1:0] xw;
    logic [XW-1:0] x_hi;
    logic          x_sat;
    assign xw    = XW'(pp_reg) << 15;
    assign x_hi  = xw >> (F + QBITS);
    assign x_sat = x_hi >= XW'(error_bound_reg);

    // Division by epsilon, one quotient bit per stage.
    always_comb
    begin
        logic [QBITS-1:0] prev_q;
        logic [16:0]      cur;
        r2_next[0] = x_hi[15:0];
        for (int j = 1; j <= QBITS; j++)
        begin
            if (j == 1)
                prev_q = '0;
            else
                prev_q = q2_reg[j-1];
            cur = {r2_reg[j-1], ctl_reg[A+6+j-1].xb[QBITS-j]};
            if (cur >= {1'b0, error_bound_reg})
            begin
                r2_next[j] = 16'(cur - {1'b0, error_bound_reg});
                q2_next[j] = {prev_q[QBITS-2:0], 1'b1};
            end
            else
            begin
                r2_next[j] = cur[15:0];
                q2_next[j] = {prev_q[QBITS-2:0], 1'b0};
            end
        end
    end

    // Control word that travels with each beat.
    always_comb
    begin
        logic [20:0] k21;
        logic [20:0] kc;
        k21 = 21'(s_tdata[16:0]);
        kc  = (k21 > 21'(MAX_CELLS)) ? 21'(MAX_CELLS) : k21;
        ctl_next[0]     = '0;
        ctl_next[0].lt2 = kc < 21'd2;
        ctl_next[0].km1 = KMW'(kc - 21'd1);
        for (int i = 1; i < L; i++)
        begin
            ctl_next[i] = ctl_reg[i-1];
            if (i == QB)
                ctl_next[i].cq = dq_next[QB][F-1:0];
            if (i == A + 2)
                ctl_next[i].neg = sub_neg;
            if (i == A + 6)
            begin
                ctl_next[i].sat    = x_sat;
                ctl_next[i].sticky = |xw[F-1:0];
                ctl_next[i].xb     = xw[F +: QBITS];
            end
        end
    end

    // Ceiling and clamping of the final count.
    always_comb
    begin
        logic [QBITS:0] n;
        n = {1'b0, q2_reg[QBITS]} +
            (QBITS+1)'((r2_reg[QBITS] != 16'd0) || ctl_reg[B].sticky);
        if (ctl_reg[B].lt2)
            out_data_next = max_samples_reg;
        else if (ctl_reg[B].neg)
            out_data_next = min_samples_reg;
        else if (ctl_reg[B].sat)
            out_data_next = max_samples_reg;
        else if (n < (QBITS+1)'(min_samples_reg))
            out_data_next = min_samples_reg;
        else if (n > (QBITS+1)'(max_samples_reg))
            out_data_next = max_samples_reg;
        else
            out_data_next = n[19:0];
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[L-2:0], s_tvalid};
            out_valid_reg <= vld_reg[L-1];
        end
    end

    // Data stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < L; i++)
                ctl_reg[i] <= ctl_next[i];
            for (int j = 1; j <= QB; j++)
            begin
                drem_reg[j] <= drem_next[j];
                dq_reg[j]   <= dq_next[j];
            end
            for (int s = 1; s <= F; s++)
            begin
                sr_reg[s]    <= sr_next[s];
                sroot_reg[s] <= sroot_next[s];
            end
            mp_reg   <= (F+16)'(sroot_reg[F]) * (F+16)'(z_quantile_reg);
            tt_reg   <= (F+1)'(one_ext - sub_sum);
            // T is delayed one stage so that it meets its own t^2.
            tt_d_reg <= tt_reg;
            t2_reg   <= (F+1)'(((2*F+2)'(tt_reg) * (2*F+2)'(tt_reg)) >> F);
            t3_reg   <= (F+1)'(((2*F+2)'(t2_reg) * (2*F+2)'(tt_d_reg)) >> F);
            pp_reg   <= PW'(ctl_reg[A+4].km1) * PW'(t3_reg);
            for (int j = 0; j <= QBITS; j++)
                r2_reg[j] <= r2_next[j];
            for (int j = 1; j <= QBITS; j++)
                q2_reg[j] <= q2_next[j];
            out_data_reg <= out_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A held pipeline keeps its valid bits.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    // A new output beat comes only from the last pipeline stage.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(vld_reg[L-1]))
        else $error("output beat without a beat in the last stage");

    // The input side is ready whenever the output register is free.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");
`endif

endmodule
